>>> rtl/roq_pkg.sv
`default_nettype none

package roq_pkg;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HEAD,
        S_SCAN,
        S_SHIFT,
        S_FINISH,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic head_adv;
    } ring_ctl_t;

endpackage

`default_nettype wire

>>> rtl/roq_ring.sv
`default_nettype none

module roq_ring #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32,
    parameter int ADDR_W   = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire roq_pkg::ring_ctl_t   ctl,
    input  wire logic [ADDR_W-1:0]    rd_idx,
    input  wire logic [ADDR_W-1:0]    wr_idx,
    input  wire logic [KEY_BITS-1:0]  wr_data,
    output logic      [KEY_BITS-1:0]  rd_data
);
    import roq_pkg::*;

    localparam logic [ADDR_W:0] DEPTH_V = (ADDR_W+1)'(DEPTH);

    logic [KEY_BITS-1:0] key_mem [DEPTH];
    logic [KEY_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]   head_reg;
    logic [ADDR_W-1:0]   head_next;
    logic [ADDR_W:0]     rd_sum;
    logic [ADDR_W:0]     wr_sum;
    logic [ADDR_W:0]     head_sum;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;

    always_comb
    begin
        rd_sum   = {1'b0, head_reg} + {1'b0, rd_idx};
        wr_sum   = {1'b0, head_reg} + {1'b0, wr_idx};
        head_sum = {1'b0, head_reg} + (ADDR_W+1)'(1);
        rd_addr  = (rd_sum >= DEPTH_V) ? ADDR_W'(rd_sum - DEPTH_V) : rd_sum[ADDR_W-1:0];
        wr_addr  = (wr_sum >= DEPTH_V) ? ADDR_W'(wr_sum - DEPTH_V) : wr_sum[ADDR_W-1:0];
        head_next = head_reg;
        if (ctl.head_adv)
        begin
            head_next = (head_sum >= DEPTH_V) ? '0 : head_sum[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/replacement_order_queue.sv
// Channel   Signals                               Direction
// --------  ------------------------------------  ---------
// request   req_valid, req_ready, command, key     in
// response  rsp_valid, rsp_ready, key_out,        out
//           status, length
//
// One transaction at a time; req_ready is high only while the sequencer is idle.
// Push, unused commands and pop or rotate on an empty list go straight to the response;
// other pops and rotates read the head; remove and touch do one compare per entry to find
// the key, then one copy per entry behind it, through the one-read, one-write ring memory.
// Reset clears the length, head pointer and sequencer; stored keys are not cleared.
// A waiting response does not block the next request; its result waits to load.
`default_nettype none

module replacement_order_queue #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire logic [roq_pkg::CMD_W-1:0]         command,
    input  wire logic [roq_pkg::KEY_W-1:0]         key,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic      [roq_pkg::KEY_W-1:0]         key_out,
    output logic      [roq_pkg::STATUS_W-1:0]      status,
    output logic      [roq_pkg::LEN_W-1:0]         length
);
    import roq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    seq_state_t state_reg, state_next;

    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [KEY_W-1:0]    kout_reg, kout_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [KEY_W-1:0]    rsp_key_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [LEN_W-1:0]    rsp_len_reg;

    ring_ctl_t           ring_ctl;
    logic [ADDR_W-1:0]   rd_idx;
    logic [ADDR_W-1:0]   wr_idx;
    logic [KEY_BITS-1:0] wr_data;
    logic [KEY_BITS-1:0] rd_data;

    logic [KEY_BITS+KEY_W-1:0] key_wide;
    logic [KEY_W+KEY_BITS-1:0] rd_wide;
    logic [LEN_W+CNT_W-1:0]    len_wide;
    logic [KEY_BITS-1:0]       key_in;
    logic [KEY_W-1:0]          rd_key_out;
    logic [LEN_W-1:0]          len_out;

    logic                count_full;
    logic                count_zero;
    logic [CNT_W-1:0]    idx_ext;
    logic [CNT_W:0]      idx_p1;
    logic [CNT_W:0]      idx_p2;
    logic                more1;
    logic                more2;
    logic [ADDR_W-1:0]   tail_idx;
    logic [ADDR_W-1:0]   last_idx;
    logic [CNT_W-1:0]    count_dec;
    logic                hit;
    logic                rsp_load;
    logic                req_accept;

    roq_ring #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .ADDR_W   (ADDR_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .rd_idx  (rd_idx),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign key_wide   = {{KEY_BITS{1'b0}}, key};
    assign key_in     = key_wide[KEY_BITS-1:0];
    assign rd_wide    = {{KEY_W{1'b0}}, rd_data};
    assign rd_key_out = rd_wide[KEY_W-1:0];
    assign len_wide   = {{LEN_W{1'b0}}, count_reg};
    assign len_out    = len_wide[LEN_W-1:0];

    assign count_full = (count_reg == CNT_W'(DEPTH));
    assign count_zero = (count_reg == '0);
    assign idx_ext    = CNT_W'(idx_reg);
    assign idx_p1     = {1'b0, idx_ext} + (CNT_W+1)'(1);
    assign idx_p2     = {1'b0, idx_ext} + (CNT_W+1)'(2);
    assign more1      = (idx_p1 < {1'b0, count_reg});
    assign more2      = (idx_p2 < {1'b0, count_reg});
    assign count_dec  = count_reg - CNT_W'(1);
    assign tail_idx   = count_full ? '0 : count_reg[ADDR_W-1:0];
    assign last_idx   = count_dec[ADDR_W-1:0];
    assign hit        = (rd_data == key_reg);

    assign req_ready  = (state_reg == S_IDLE);
    assign req_accept = req_valid && req_ready;
    assign rsp_load   = (state_reg == S_RESP) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_POP, CMD_ROTATE:
                    begin
                        state_next = count_zero ? S_RESP : S_HEAD;
                    end
                    CMD_REMOVE, CMD_TOUCH:
                    begin
                        state_next = count_zero ? S_RESP : S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_HEAD:
            begin
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = more1 ? S_SHIFT : S_FINISH;
                end
                else if (!more1)
                begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT:
            begin
                if (!more2)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        kout_next   = kout_reg;
        ring_ctl    = '0;
        rd_idx      = '0;
        wr_idx      = '0;
        wr_data     = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    cmd_next    = command;
                    key_next    = key_in;
                    status_next = STAT_OK;
                    kout_next   = '0;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (count_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ring_ctl.wr_en = 1'b1;
                            wr_idx         = tail_idx;
                            count_next     = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP, CMD_ROTATE:
                    begin
                        if (count_zero)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            ring_ctl.rd_en = 1'b1;
                        end
                    end
                    CMD_REMOVE, CMD_TOUCH:
                    begin
                        if (count_zero)
                        begin
                            status_next = STAT_MISSING;
                        end
                        else
                        begin
                            ring_ctl.rd_en = 1'b1;
                            idx_next       = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_HEAD:
            begin
                kout_next         = rd_key_out;
                ring_ctl.head_adv = 1'b1;
                if (cmd_reg == CMD_ROTATE)
                begin
                    ring_ctl.wr_en = 1'b1;
                    wr_idx         = tail_idx;
                    wr_data        = rd_data;
                end
                else
                begin
                    count_next = count_dec;
                end
            end
            S_SCAN:
            begin
                if (more1)
                begin
                    ring_ctl.rd_en = 1'b1;
                    rd_idx         = idx_p1[ADDR_W-1:0];
                end
                if (!hit)
                begin
                    if (more1)
                    begin
                        idx_next = idx_p1[ADDR_W-1:0];
                    end
                    else
                    begin
                        status_next = STAT_MISSING;
                    end
                end
            end
            S_SHIFT:
            begin
                ring_ctl.wr_en = 1'b1;
                wr_idx         = idx_reg;
                wr_data        = rd_data;
                idx_next       = idx_p1[ADDR_W-1:0];
                if (more2)
                begin
                    ring_ctl.rd_en = 1'b1;
                    rd_idx         = idx_p2[ADDR_W-1:0];
                end
            end
            S_FINISH:
            begin
                if (cmd_reg == CMD_TOUCH)
                begin
                    ring_ctl.wr_en = 1'b1;
                    wr_idx         = last_idx;
                end
                else
                begin
                    count_next = count_dec;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        kout_reg   <= kout_next;
        if (rsp_load)
        begin
            rsp_key_reg    <= kout_reg;
            rsp_status_reg <= status_reg;
            rsp_len_reg    <= len_out;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign key_out   = rsp_key_reg;
    assign status    = rsp_status_reg;
    assign length    = rsp_len_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list length above depth");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response raised outside the response state");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_EMPTY |-> length == '0)
        else $error("empty status with nonzero length");

    a_key_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STAT_OK |-> key_out == '0)
        else $error("key returned on a failed transaction");

endmodule

`default_nettype wire

>>> tb/replacement_order_queue_test.sv
module replacement_order_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import roq_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int SIDE_REQ     = 0;
    localparam int SIDE_RSP     = 1;

    localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;

    typedef struct packed {
        logic [KEY_W-1:0]    key_out;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    length;
    } reply_t;

    class order_scoreboard;
        logic [KEY_W-1:0] held_keys[$];
        reply_t           awaited[$];
        int               errors;
        int               replies;
        int               status_seen[4];

        function int oldest_match(logic [KEY_W-1:0] k);
            foreach (held_keys[i])
            begin
                if (held_keys[i] == k)
                    return i;
            end
            return -1;
        endfunction

        function logic [KEY_W-1:0] any_held();
            if (held_keys.size() == 0)
                return $urandom();
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
            reply_t           r;
            int               pos;
            logic [KEY_W-1:0] moved;
            r = '0;
            r.status = STAT_OK;
            case (cmd)
                CMD_PUSH:
                    if (held_keys.size() >= LIST_DEPTH)
                        r.status = STAT_FULL;
                    else
                        held_keys.push_back(k);
                CMD_POP:
                    if (held_keys.size() == 0)
                        r.status = STAT_EMPTY;
                    else
                        r.key_out = held_keys.pop_front();
                CMD_ROTATE:
                    if (held_keys.size() == 0)
                        r.status = STAT_EMPTY;
                    else
                    begin
                        r.key_out = held_keys.pop_front();
                        held_keys.push_back(r.key_out);
                    end
                CMD_REMOVE:
                begin
                    pos = oldest_match(k);
                    if (pos < 0)
                        r.status = STAT_MISSING;
                    else
                        held_keys.delete(pos);
                end
                CMD_TOUCH:
                begin
                    pos = oldest_match(k);
                    if (pos < 0)
                        r.status = STAT_MISSING;
                    else
                    begin
                        moved = held_keys[pos];
                        held_keys.delete(pos);
                        held_keys.push_back(moved);
                    end
                end
                default:
                    ;
            endcase
            r.length = LEN_W'(held_keys.size());
            status_seen[r.status]++;
            awaited.push_back(r);
        endfunction

        function void check_reply(logic [KEY_W-1:0] ko, logic [STATUS_W-1:0] st,
                                  logic [LEN_W-1:0] len);
            reply_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected response: key_out %h status %0d length %0d", ko, st, len);
                errors++;
                return;
            end
            want = awaited.pop_front();
            replies++;
            if (ko !== want.key_out)
            begin
                $error("key_out: expected %h, got %h", want.key_out, ko);
                errors++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
            if (len !== want.length)
            begin
                $error("length: expected %0d, got %0d", want.length, len);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [CMD_W-1:0]    command = '0;
    logic [KEY_W-1:0]    key = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [KEY_W-1:0]    key_out;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;

    order_scoreboard sb = new();

    int calm_left[2];
    bit calm[2];
    bit held_off;

    replacement_order_queue #(
        .DEPTH    (LIST_DEPTH),
        .KEY_BITS (KEY_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (command),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .key_out   (key_out),
        .status    (status),
        .length    (length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // alternate stretches of back-to-back traffic with random gaps
    function automatic int draw_gap(int side);
        if (calm_left[side] == 0)
        begin
            calm[side] = ($urandom_range(0, 2) == 0);
            calm_left[side] = $urandom_range(10, 60);
        end
        calm_left[side]--;
        return calm[side] ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
        int gap;
        gap = draw_gap(SIDE_REQ);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid = 1'b0;
        end
        @(negedge clk);
        req_valid = 1'b1;
        command = cmd;
        key = k;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(cmd, k);
    endtask

    task automatic send_random_item(int fill_bias);
        int               roll;
        int               push_cut;
        int               mid;
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] k;
        push_cut = (fill_bias == 2) ? 55 : (fill_bias == 0) ? 15 : 32;
        mid = (push_cut + 25 + 96) / 2;
        roll = $urandom_range(0, 99);
        if (roll < push_cut)
            cmd = CMD_PUSH;
        else if (roll < push_cut + 15)
            cmd = CMD_POP;
        else if (roll < push_cut + 25)
            cmd = CMD_ROTATE;
        else if (roll < mid)
            cmd = CMD_REMOVE;
        else if (roll < 96)
            cmd = CMD_TOUCH;
        else
            cmd = CMD_W'($urandom_range(CMD_TOUCH + 1, CMD_LAST_CODE));
        pick = $urandom_range(0, 9);
        if (cmd == CMD_PUSH)
            k = (pick < 5) ? $urandom_range(0, 15) : (pick < 6) ? sb.any_held() : $urandom();
        else if (cmd == CMD_REMOVE || cmd == CMD_TOUCH)
            k = (pick < 7) ? sb.any_held() : (pick < 8) ? $urandom_range(0, 15) : $urandom();
        else
            k = $urandom();
        send_item(cmd, k);
    endtask

    initial
    begin
        #7_000_000;
        $display("FAIL replacement_order_queue");
        $finish;
    end

    // response side, with one long hold-off to back the block up
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(SIDE_RSP);
            if (!held_off && sb.replies >= HOLD_AT)
            begin
                held_off = 1'b1;
                gap = HOLD_CYCLES;
            end
            repeat (gap)
            begin
                @(negedge clk);
                rsp_ready = 1'b0;
            end
            @(negedge clk);
            rsp_ready = 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            sb.check_reply(key_out, status, length);
        end
    end

    initial
    begin
        int fill_bias;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        send_item(CMD_POP, '0);
        send_item(CMD_ROTATE, '1);
        send_item(CMD_REMOVE, 32'h1234_5678);
        send_item(CMD_TOUCH, '1);
        send_item(CMD_PUSH, '0);
        send_item(CMD_ROTATE, '0);
        for (int i = 1; i < LIST_DEPTH; i++)
            send_item(CMD_PUSH, (i == LIST_DEPTH - 1) ? '1 :
                                (i % 4 == 0) ? 32'h0 : (32'hA5A5_0000 | i));
        send_item(CMD_PUSH, 32'hDEAD_BEEF);
        send_item(CMD_TOUCH, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_W'(CMD_TOUCH + 1), 32'h5A5A_5A5A);
        send_item(CMD_LAST_CODE, '1);
        send_item(CMD_POP, '1);

        fill_bias = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 120 == 0)
                fill_bias = $urandom_range(0, 2);
            send_random_item(fill_bias);
        end
        @(negedge clk);
        req_valid = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d transactions through fill, drain, duplicate keys and a long stall",
                 sb.replies);
        $display("status mix: ok %0d, empty %0d, full %0d, missing %0d, errors %0d",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY],
                 sb.status_seen[STAT_FULL], sb.status_seen[STAT_MISSING], sb.errors);
        if (sb.errors == 0)
            $display("PASS replacement_order_queue");
        else
            $display("FAIL replacement_order_queue");
        $finish;
    end
endmodule
